// ===== design/wpa_pkg.sv =====
package wpa_pkg;

    localparam int MAX_POOL   = 4;
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 1024;
    localparam int ROW_BITS   = $clog2(MAX_POOL);
    localparam int COL_BITS   = $clog2(MAX_WIDTH);

    localparam logic [1:0] MODE_MAX = 2'd0;
    localparam logic [1:0] MODE_MIN = 2'd1;
    localparam logic [1:0] MODE_AVG = 2'd2;

    localparam logic [2:0] CFG_POOL   = 3'd0;
    localparam logic [2:0] CFG_STRIDE = 3'd1;
    localparam logic [2:0] CFG_MODE   = 3'd2;
    localparam logic [2:0] CFG_WIDTH  = 3'd3;
    localparam logic [2:0] CFG_HEIGHT = 3'd4;

    typedef struct packed {
        logic       start;
        logic       step;
        logic [3:0] elem;
        logic       finish;
    } wpa_cmd_t;

    typedef struct packed {
        logic busy;
    } wpa_stat_t;

endpackage

// ===== design/wpa_datapath.sv =====
module wpa_datapath (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [wpa_pkg::ROW_BITS-1:0]    wr_row,
    input  logic [wpa_pkg::COL_BITS-1:0]    wr_col,
    input  logic signed [15:0]              wr_data,
    input  logic [11:0]                     r0,
    input  logic [11:0]                     c0,
    input  logic [2:0]                      pool,
    input  logic [1:0]                      mode,
    input  wpa_pkg::wpa_cmd_t               cmd,
    output logic signed [15:0]              result,
    output logic [3:0]                      winner
);
    import wpa_pkg::*;

    logic signed [15:0] mem [MAX_POOL*MAX_WIDTH];
    logic signed [15:0] rd_reg;
    logic [3:0]         rd_idx_reg;
    logic               rd_vld_reg;
    logic               rd_first_reg;
    logic signed [15:0] best_reg, best_next;
    logic [3:0]         win_reg, win_next;
    logic signed [20:0] sum_reg, sum_next;
    logic [11:0]        ar, ac;
    logic [ROW_BITS+COL_BITS-1:0] waddr, raddr;
    logic               better;
    logic [15:0]        quot;

    always_comb
    begin
        logic [3:0] rr, cc;
        rr = 4'd0;
        cc = 4'd0;
        unique case (pool)
            3'd1:    begin rr = 4'd0; cc = 4'd0; end
            3'd2:    begin rr = {3'd0, cmd.elem[1]}; cc = {3'd0, cmd.elem[0]}; end
            3'd3:
            begin
                rr = (cmd.elem >= 4'd6) ? 4'd2 : (cmd.elem >= 4'd3) ? 4'd1 : 4'd0;
                cc = cmd.elem - 4'(rr * 3);
            end
            default: begin rr = {2'd0, cmd.elem[3:2]}; cc = {2'd0, cmd.elem[1:0]}; end
        endcase
        ar = r0 + 12'(rr);
        ac = c0 + 12'(cc);
    end

    assign waddr = {wr_row, wr_col};
    assign raddr = {ar[ROW_BITS-1:0], ac[COL_BITS-1:0]};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= wr_data;
        end
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        rd_vld_reg   <= cmd.step;
        rd_first_reg <= cmd.start;
        rd_idx_reg   <= cmd.elem;
        best_reg     <= best_next;
        win_reg      <= win_next;
        sum_reg      <= sum_next;
    end

    assign better = (mode == MODE_MIN) ? (rd_reg < best_reg) : (rd_reg > best_reg);

    always_comb
    begin
        best_next = best_reg;
        win_next  = win_reg;
        sum_next  = sum_reg;
        if (rd_vld_reg)
        begin
            if (rd_first_reg)
            begin
                best_next = rd_reg;
                win_next  = 4'd0;
                sum_next  = 21'(rd_reg);
            end
            else
            begin
                sum_next = sum_reg + 21'(rd_reg);
                if (better)
                begin
                    best_next = rd_reg;
                    win_next  = rd_idx_reg;
                end
            end
        end
    end

    always_comb
    begin
        logic [20:0] mag;
        logic [20:0] q;
        logic [41:0] prod;
        mag  = sum_reg[20] ? 21'(-sum_reg) : sum_reg;
        q    = 21'd0;
        prod = 42'd0;
        unique case (pool)
            3'd1:    q = mag;
            3'd2:    q = mag >> 2;
            3'd3:
            begin
                prod = 42'(mag) * 42'd233017;
                q    = 21'(prod >> 21);
                if (mag - 21'(q * 9) >= 21'd9)
                begin
                    q = q + 21'd1;
                end
            end
            default: q = mag >> 4;
        endcase
        quot = sum_reg[20] ? 16'(-q) : 16'(q);
    end

    assign result = (mode == MODE_AVG) ? $signed(quot) : best_reg;
    assign winner = (mode == MODE_AVG) ? 4'd0 : win_reg;

endmodule

// ===== design/wpa_ctrl.sv =====
module wpa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [2:0]        pool,
    output wpa_pkg::wpa_cmd_t cmd,
    output wpa_pkg::wpa_stat_t stat
);
    import wpa_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_TAIL = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [3:0] elem_reg, elem_next;
    logic [4:0] last;

    assign last = 5'(pool * pool) - 5'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            elem_reg  <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            elem_reg  <= elem_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        elem_next  = elem_reg;
        cmd        = '0;
        cmd.elem   = elem_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    state_next = S_READ;
                    elem_next  = 4'd0;
                end
            end
            S_READ:
            begin
                cmd.step  = 1'b1;
                cmd.start = (elem_reg == 4'd0);
                if (5'(elem_reg) == last)
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    elem_next = elem_reg + 4'd1;
                end
            end
            S_TAIL:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        stat.busy = (state_reg != S_IDLE);
    end

endmodule

// ===== design/window_pooling_with_argmax.sv =====
// Channel | Signals                                   | Direction
// input   | in_valid, in_stall, sample_value          | into the block
// output  | out_valid, out_stall, pooled_value ...    | out of the block
// config  | cfg_we, cfg_index, cfg_data               | into the block
//
// A word that completes no window does not stall the input.
// A completing word stalls it while the single line-store read port feeds the
// window, sample by sample, to the shared comparator and accumulator.
// The result sits in an output register; a stall there holds new input only
// once the next window is ready. Reset restores the register defaults.
module window_pooling_with_argmax (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [10:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] sample_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] pooled_value,
    output logic [3:0]         winner_index,
    output logic [9:0]         out_row,
    output logic [7:0]         out_col,
    output logic               plane_end
);
    import wpa_pkg::*;

    logic [2:0]  pool_cfg_reg;
    logic [3:0]  stride_cfg_reg;
    logic [1:0]  mode_reg;
    logic [8:0]  width_cfg_reg;
    logic [10:0] height_cfg_reg;
    logic [11:0] col_reg, row_reg;
    logic [3:0]  rm_reg, cm_reg;
    logic [11:0] rq_reg, cq_reg;
    logic [2:0]  p;
    logic [3:0]  s;
    logic [12:0] w, h;
    logic [3:0]  pm;
    logic [11:0] pt;
    logic        hit, in_acc, go, busy_out, load, last_win;
    logic [11:0] r0, c0, oi, oj;
    logic [11:0] r0_reg, c0_reg, oi_reg, oj_reg;
    logic        last_reg;
    logic        pending_reg;
    wpa_cmd_t    cmd;
    wpa_stat_t   stat;
    logic signed [15:0] dp_result;
    logic [3:0]  dp_win;

    assign p = (pool_cfg_reg == 3'd0) ? 3'd1 :
               (32'(pool_cfg_reg) > MAX_POOL) ? 3'(MAX_POOL) : pool_cfg_reg;
    assign s = (stride_cfg_reg == 4'd0) ? 4'd1 : stride_cfg_reg;
    assign w = (width_cfg_reg == 9'd0) ? 13'd1 :
               (32'(width_cfg_reg) > MAX_WIDTH) ? 13'(MAX_WIDTH) : 13'(width_cfg_reg);
    assign h = (height_cfg_reg == 11'd0) ? 13'd1 :
               (32'(height_cfg_reg) > MAX_HEIGHT) ? 13'(MAX_HEIGHT) : 13'(height_cfg_reg);

    always_comb
    begin
        pm = 4'(p) - 4'd1;
        pt = 12'd0;
        for (int i = 0; i < 3; i++)
        begin
            if (pm >= s)
            begin
                pm = pm - s;
                pt = pt + 12'd1;
            end
        end
    end

    assign r0 = row_reg + 12'd1 - 12'(p);
    assign c0 = col_reg + 12'd1 - 12'(p);
    assign oi = rq_reg - pt;
    assign oj = cq_reg - pt;
    assign hit = (row_reg + 12'd1 >= 12'(p)) && (col_reg + 12'd1 >= 12'(p)) &&
                 (rm_reg == pm) && (cm_reg == pm);
    assign last_win = (13'(row_reg) + 13'd1 + 13'(s) > h) &&
                      (13'(col_reg) + 13'd1 + 13'(s) > w);

    assign in_stall = stat.busy || pending_reg;
    assign in_acc   = in_valid && !in_stall;
    assign go       = in_acc && hit;
    assign busy_out = out_valid && out_stall;
    assign load     = (cmd.finish || pending_reg) && !busy_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_cfg_reg   <= 3'd2;
            stride_cfg_reg <= 4'd2;
            mode_reg       <= MODE_MAX;
            width_cfg_reg  <= 9'd28;
            height_cfg_reg <= 11'd28;
            col_reg        <= 12'd0;
            row_reg        <= 12'd0;
            rm_reg         <= 4'd0;
            rq_reg         <= 12'd0;
            cm_reg         <= 4'd0;
            cq_reg         <= 12'd0;
            out_valid      <= 1'b0;
            pending_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_POOL:   pool_cfg_reg   <= cfg_data[2:0];
                    CFG_STRIDE: stride_cfg_reg <= cfg_data[3:0];
                    CFG_MODE:   mode_reg       <= cfg_data[1:0];
                    CFG_WIDTH:  width_cfg_reg  <= cfg_data[8:0];
                    CFG_HEIGHT: height_cfg_reg <= cfg_data[10:0];
                    default: ;
                endcase
                if (cfg_index <= CFG_HEIGHT)
                begin
                    col_reg <= 12'd0;
                    row_reg <= 12'd0;
                    rm_reg  <= 4'd0;
                    rq_reg  <= 12'd0;
                    cm_reg  <= 4'd0;
                    cq_reg  <= 12'd0;
                end
            end
            else if (in_acc)
            begin
                if (13'(col_reg) + 13'd1 >= w)
                begin
                    col_reg <= 12'd0;
                    cm_reg  <= 4'd0;
                    cq_reg  <= 12'd0;
                    if (13'(row_reg) + 13'd1 >= h)
                    begin
                        row_reg <= 12'd0;
                        rm_reg  <= 4'd0;
                        rq_reg  <= 12'd0;
                    end
                    else
                    begin
                        row_reg <= row_reg + 12'd1;
                        if (rm_reg + 4'd1 == s)
                        begin
                            rm_reg <= 4'd0;
                            rq_reg <= rq_reg + 12'd1;
                        end
                        else
                        begin
                            rm_reg <= rm_reg + 4'd1;
                        end
                    end
                end
                else
                begin
                    col_reg <= col_reg + 12'd1;
                    if (cm_reg + 4'd1 == s)
                    begin
                        cm_reg <= 4'd0;
                        cq_reg <= cq_reg + 12'd1;
                    end
                    else
                    begin
                        cm_reg <= cm_reg + 4'd1;
                    end
                end
            end
            if (load)
            begin
                out_valid   <= 1'b1;
                pending_reg <= 1'b0;
            end
            else
            begin
                if (out_valid && !out_stall)
                begin
                    out_valid <= 1'b0;
                end
                if (cmd.finish)
                begin
                    pending_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            r0_reg   <= r0;
            c0_reg   <= c0;
            oi_reg   <= oi;
            oj_reg   <= oj;
            last_reg <= last_win;
        end
        if (load)
        begin
            pooled_value <= dp_result;
            winner_index <= dp_win;
            out_row      <= oi_reg[9:0];
            out_col      <= oj_reg[7:0];
            plane_end    <= last_reg;
        end
    end

    wpa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .pool  (p),
        .cmd   (cmd),
        .stat  (stat)
    );

    wpa_datapath u_dp (
        .clk     (clk),
        .wr_en   (in_acc),
        .wr_row  (row_reg[ROW_BITS-1:0]),
        .wr_col  (col_reg[COL_BITS-1:0]),
        .wr_data (sample_value),
        .r0      (r0_reg),
        .c0      (c0_reg),
        .pool    (p),
        .mode    (mode_reg),
        .cmd     (cmd),
        .result  (dp_result),
        .winner  (dp_win)
    );

endmodule

// ===== bench/window_pooling_with_argmax_tb.sv =====
`timescale 1ns / 100ps

module window_pooling_with_argmax_tb;
    import wpa_pkg::*;

    typedef enum logic [1:0] { W_SAMPLE, W_CFG, W_DRAIN } word_kind_t;

    typedef struct {
        word_kind_t         kind;
        logic [2:0]         idx;
        logic [10:0]        data;
        logic signed [15:0] value;
    } stim_word_t;

    typedef struct {
        logic signed [15:0] pooled;
        logic [3:0]         winner;
        logic [9:0]         row;
        logic [7:0]         col;
        logic               last;
    } pool_result_t;

    localparam int SETTLE = 32;
    localparam int STALL_LIMIT = 4000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [10:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [15:0] sample_value = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] pooled_value;
    logic [3:0]         winner_index;
    logic [9:0]         out_row;
    logic [7:0]         out_col;
    logic               plane_end;

    stim_word_t   pending_words[$];
    pool_result_t expected_windows[$];

    logic [2:0]         pool_reg;
    logic [3:0]         stride_reg;
    logic [1:0]         mode_reg;
    logic [8:0]         width_reg;
    logic [10:0]        height_reg;
    logic signed [15:0] line_rows[4][256];
    int                 col_pos;
    int                 row_pos;

    bit in_fire;
    int quiet_cycles;
    int idle_cycles;
    int sent_samples;
    int result_count;
    int cfg_count;
    int error_count;
    bit calm;

    window_pooling_with_argmax dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_value (sample_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pooled_value (pooled_value),
        .winner_index (winner_index),
        .out_row      (out_row),
        .out_col      (out_col),
        .plane_end    (plane_end)
    );

    always #5 clk = ~clk;

    function automatic void apply_register(logic [2:0] idx, logic [10:0] data);
        case (idx)
            CFG_POOL:   pool_reg = data[2:0];
            CFG_STRIDE: stride_reg = data[3:0];
            CFG_MODE:   mode_reg = data[1:0];
            CFG_WIDTH:  width_reg = data[8:0];
            CFG_HEIGHT: height_reg = data[10:0];
            default:    return;
        endcase
        col_pos = 0;
        row_pos = 0;
    endfunction

    function automatic void pool_sample(logic signed [15:0] v);
        int p;
        int s;
        int w;
        int h;
        int r;
        int c;
        int r0;
        int c0;
        int sum;
        int best;
        int cur;
        int win;
        pool_result_t res;
        p = (pool_reg == 0) ? 1 : (pool_reg > 4) ? 4 : pool_reg;
        s = (stride_reg == 0) ? 1 : stride_reg;
        w = (width_reg == 0) ? 1 : (width_reg > 256) ? 256 : width_reg;
        h = (height_reg == 0) ? 1 : (height_reg > 1024) ? 1024 : height_reg;
        r = (row_pos >= h) ? 0 : row_pos;
        c = (col_pos >= w) ? 0 : col_pos;
        line_rows[r % 4][c] = v;
        if (r + 1 >= p && c + 1 >= p && (r + 1 - p) % s == 0 && (c + 1 - p) % s == 0)
        begin
            r0 = r + 1 - p;
            c0 = c + 1 - p;
            win = 0;
            sum = 0;
            best = line_rows[r0 % 4][c0];
            for (int i = 0; i < p; i++)
            begin
                for (int j = 0; j < p; j++)
                begin
                    cur = line_rows[(r0 + i) % 4][c0 + j];
                    sum += cur;
                    if ((mode_reg == MODE_MIN) ? (cur < best) : (cur > best))
                    begin
                        best = cur;
                        win = i * p + j;
                    end
                end
            end
            if (mode_reg == MODE_AVG)
            begin
                res.pooled = 16'(sum / (p * p));
                res.winner = '0;
            end
            else
            begin
                res.pooled = 16'(best);
                res.winner = 4'(win);
            end
            res.row = 10'(r0 / s);
            res.col = 8'(c0 / s);
            res.last = (r0 / s + 1 == (h - p) / s + 1) && (c0 / s + 1 == (w - p) / s + 1);
            expected_windows.push_back(res);
        end
        if (c + 1 >= w)
        begin
            c = 0;
            r = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            c = c + 1;
        end
        col_pos = c;
        row_pos = r;
    endfunction

    always @(posedge clk)
    begin
        pool_result_t exp_res;
        if (rst_n)
        begin
            in_fire = in_valid && !in_stall;
            if (cfg_we)
            begin
                apply_register(cfg_index, cfg_data);
                cfg_count++;
            end
            if (in_fire)
                pool_sample(sample_value);
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (expected_windows.size() == 0)
                begin
                    $error("unexpected result: pooled_value %0d", pooled_value);
                    error_count++;
                end
                else
                begin
                    exp_res = expected_windows.pop_front();
                    if (pooled_value !== exp_res.pooled)
                    begin
                        $error("pooled_value: expected %0d, actual %0d",
                               exp_res.pooled, pooled_value);
                        error_count++;
                    end
                    if (winner_index !== exp_res.winner)
                    begin
                        $error("winner_index: expected %0d, actual %0d",
                               exp_res.winner, winner_index);
                        error_count++;
                    end
                    if (out_row !== exp_res.row)
                    begin
                        $error("out_row: expected %0d, actual %0d", exp_res.row, out_row);
                        error_count++;
                    end
                    if (out_col !== exp_res.col)
                    begin
                        $error("out_col: expected %0d, actual %0d", exp_res.col, out_col);
                        error_count++;
                    end
                    if (plane_end !== exp_res.last)
                    begin
                        $error("plane_end: expected %0d, actual %0d", exp_res.last, plane_end);
                        error_count++;
                    end
                end
            end
            if (in_fire || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (in_fire || (out_valid && !out_stall) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        stim_word_t w;
        logic next_valid;
        logic next_we;
        if (rst_n)
        begin
            calm = (sent_samples >= 600 && sent_samples < 800);
            out_stall <= !calm && ($urandom_range(99) < 12);
            if (!(in_valid && !in_fire))
            begin
                next_valid = 1'b0;
                next_we = 1'b0;
                if (pending_words.size() != 0)
                begin
                    w = pending_words[0];
                    case (w.kind)
                        W_SAMPLE:
                            if (calm || $urandom_range(99) >= 12)
                            begin
                                next_valid = 1'b1;
                                sample_value <= w.value;
                                sent_samples++;
                                void'(pending_words.pop_front());
                            end
                        W_CFG:
                            if (expected_windows.size() == 0 && quiet_cycles >= SETTLE)
                            begin
                                next_we = 1'b1;
                                cfg_index <= w.idx;
                                cfg_data <= w.data;
                                void'(pending_words.pop_front());
                            end
                        default:
                            if (expected_windows.size() == 0 && quiet_cycles >= SETTLE)
                                void'(pending_words.pop_front());
                    endcase
                end
                in_valid <= next_valid;
                cfg_we <= next_we;
            end
            else
            begin
                cfg_we <= 1'b0;
            end
        end
    end

    function automatic void add_cfg(logic [2:0] idx, logic [10:0] data);
        stim_word_t w;
        w.kind = W_CFG;
        w.idx = idx;
        w.data = data;
        w.value = '0;
        pending_words.push_back(w);
    endfunction

    function automatic void add_sample(logic signed [15:0] v);
        stim_word_t w;
        w.kind = W_SAMPLE;
        w.idx = '0;
        w.data = '0;
        w.value = v;
        pending_words.push_back(w);
    endfunction

    function automatic void add_pause();
        stim_word_t w;
        w.kind = W_DRAIN;
        w.idx = '0;
        w.data = '0;
        w.value = '0;
        pending_words.push_back(w);
    endfunction

    function automatic void add_setup(int p, int s, int m, int wd, int ht);
        add_cfg(CFG_POOL, 11'(p));
        add_cfg(CFG_STRIDE, 11'(s));
        add_cfg(CFG_MODE, 11'(m));
        add_cfg(CFG_WIDTH, 11'(wd));
        add_cfg(CFG_HEIGHT, 11'(ht));
    endfunction

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'(int'($urandom_range(3)) - 1);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        int total;
        int wd;
        int ht;
        int n;
        int p;
        pool_reg = 3'd2;
        stride_reg = 4'd2;
        mode_reg = MODE_MAX;
        width_reg = 9'd28;
        height_reg = 11'd28;
        col_pos = 0;
        row_pos = 0;

        add_setup(2, 1, int'(MODE_MAX), 4, 2);
        add_sample(16'sh7FFF);
        add_sample(16'sh8000);
        add_sample(16'sh7FFF);
        add_sample(16'sh0000);
        add_sample(16'sh0001);
        add_sample(16'sh7FFF);
        add_sample(16'shFFFF);
        add_sample(16'sh8000);
        add_cfg(CFG_MODE, 11'(MODE_MIN));
        repeat (4) add_sample(16'sh0005);
        add_sample(16'sh8000);
        add_sample(16'sh8000);
        add_sample(16'sh0005);
        add_sample(16'sh8000);
        add_cfg(CFG_MODE, 11'(MODE_AVG));
        add_sample(16'sh8000);
        add_sample(16'sh8001);
        add_sample(16'shFFFF);
        add_sample(16'sh8000);
        add_sample(16'sh0002);
        add_sample(16'sh7FFF);
        add_setup(3, 1, int'(MODE_MAX), 2, 1);
        add_sample(16'sh1234);
        add_sample(16'shEDCB);
        total = 24;

        while (total < 1550)
        begin
            add_pause();
            p = $urandom_range(7);
            case ($urandom_range(9))
                0:
                begin
                    wd = $urandom_range(256, 511);
                    ht = $urandom_range(1, 5);
                end
                1:
                begin
                    wd = $urandom_range(0, 2);
                    ht = $urandom_range(1024, 2047);
                end
                2:
                begin
                    wd = 0;
                    ht = 0;
                end
                default:
                begin
                    wd = $urandom_range(1, 12);
                    ht = $urandom_range(1, 8);
                end
            endcase
            add_setup(p, $urandom_range(15), $urandom_range(3), wd, ht);
            if ($urandom_range(3) == 0)
                add_cfg(3'($urandom_range(5, 7)), 11'($urandom));
            n = $urandom_range(20, 110);
            for (int i = 0; i < n; i++)
            begin
                add_sample(pick_value());
                if ($urandom_range(199) == 0)
                    add_pause();
            end
            total += n;
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_words.size() != 0 || in_valid || expected_windows.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Covered %0d samples, %0d register writes and %0d pooled windows,",
                 sent_samples, cfg_count, result_count);
        $display("across max, min and average modes with clamped sizes and strides.");
        if (error_count == 0 && expected_windows.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
